>>> src/ctf_pkg.sv
// ============================================================================
// ctf_pkg
// Shared types and constants of the command telegram framer.
// ============================================================================
package ctf_pkg;

    // Telegram framing bytes.
    localparam logic [7:0] BYTE_START      = 8'hAA;
    localparam logic [7:0] BYTE_END        = 8'hBB;
    localparam logic [7:0] BYTE_MARK       = 8'hCC;
    localparam logic [7:0] TYPE_ANSWER     = 8'h01;
    localparam logic [7:0] VALUE_DOUBLE    = 8'h03;
    localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

    // Input beat layout.
    localparam int RX_W    = 8;
    localparam int VALUE_W = 64;
    localparam int STAMP_W = 32;
    localparam int IN_W    = RX_W + VALUE_W + STAMP_W;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_TYPE,
        ST_NAME_RD,
        ST_NAME_OUT,
        ST_VTYPE,
        ST_VALUE,
        ST_STAMP,
        ST_END
    } ctf_state_t;

    // One unstuffed telegram byte from the sequencer to the stuffer.
    typedef struct packed {
        logic [7:0] data;
        logic       content;
        logic       last;
    } ctf_beat_t;

endpackage

>>> src/command_telegram_framer.sv
// ============================================================================
// command_telegram_framer
// Collects command bytes and answers a carriage return with a stuffed
// telegram.
// ============================================================================
// Usage: the slave stream carries one received command byte per beat together
// with the answer value, its timestamp and an error flag. Bytes other than
// carriage return are stored in the name store (NAME_BUFFER_SIZE-1 usable
// slots, later bytes dropped) and are taken at one beat per cycle. A carriage
// return starts a telegram on the master stream, one byte per beat, with
// tlast on the final byte. The carriage return moves the sequencer to its
// start state, and the first telegram byte is then registered in the output
// stage. Fixed bytes, value and stamp bytes go out at one per cycle while the
// receiver does not stall; each name byte passes a read state at the name
// store's registered read port and then an output state. An escaped byte adds
// one beat; inside the name the extra beat overlaps the store read.
// The slave side is not ready until the telegram's last byte has left the
// sequencer. When the receiver stalls, the output register and one pending
// escape byte hold, and the sequencer waits. Reset empties the name store
// and the output stage; no clearing pass is needed.
// ============================================================================
module command_telegram_framer #(
    parameter int NAME_BUFFER_SIZE = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // [7:0] rx_byte, [71:8] value_bits, [103:72] stamp
    input  logic [ctf_pkg::IN_W-1:0] s_axis_tdata,
    // [0] value_error
    input  logic [0:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]               m_axis_tdata,
    output logic                     m_axis_tlast
);

    localparam int AW = $clog2(NAME_BUFFER_SIZE);

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [7:0]         rd_data;
    logic               beat_valid;
    logic               beat_ready;
    ctf_pkg::ctf_beat_t beat;

    // Input collection and telegram sequencing.
    ctf_seq #(
        .NAME_BUFFER_SIZE (NAME_BUFFER_SIZE),
        .AW               (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .rx_byte     (s_axis_tdata[7:0]),
        .value_bits  (s_axis_tdata[71:8]),
        .stamp       (s_axis_tdata[103:72]),
        .value_error (s_axis_tuser[0]),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .beat_valid  (beat_valid),
        .beat_ready  (beat_ready),
        .beat        (beat)
    );

    // Name store.
    ctf_name_ram #(
        .DEPTH (NAME_BUFFER_SIZE),
        .AW    (AW)
    ) u_name_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Byte stuffing and output register.
    ctf_stuff u_stuff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (beat_valid),
        .in_ready  (beat_ready),
        .in_beat   (beat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

>>> src/ctf_name_ram.sv
// ============================================================================
// ctf_name_ram
// Name store: one write port and one registered read port.
// ============================================================================
module ctf_name_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/ctf_stuff.sv
// ============================================================================
// ctf_stuff
// Byte stuffer with output register and a pending slot for escaped bytes.
// ============================================================================
module ctf_stuff (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ctf_pkg::ctf_beat_t  in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic       pend_last_reg, pend_last_next;
    logic       slot_free;
    logic       in_fire;
    logic       escape;

    // The output slot frees up when empty or when its beat is taken.
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = slot_free && !pend_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign escape    = in_beat.content && (in_beat.data == ctf_pkg::BYTE_START ||
                       in_beat.data == ctf_pkg::BYTE_END || in_beat.data == ctf_pkg::BYTE_MARK);

    // Load the output slot from the pending byte first, then from the input.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_last_next  = pend_last_reg;
        if (slot_free)
        begin
            out_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = pend_byte_reg;
                out_last_next   = pend_last_reg;
                pend_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_valid_next = 1'b1;
                if (escape)
                begin
                    out_byte_next   = ctf_pkg::BYTE_MARK;
                    out_last_next   = 1'b0;
                    pend_valid_next = 1'b1;
                    pend_byte_next  = in_beat.data - 8'd1;
                    pend_last_next  = in_beat.last;
                end
                else
                begin
                    out_byte_next = in_beat.data;
                    out_last_next = in_beat.last;
                end
            end
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        pend_byte_reg <= pend_byte_next;
        pend_last_reg <= pend_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

>>> src/ctf_seq.sv
// ============================================================================
// ctf_seq
// Command collection into the name store and telegram byte sequencing.
// ============================================================================
module ctf_seq #(
    parameter int NAME_BUFFER_SIZE = 16,
    parameter int AW               = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    input  logic [63:0]            value_bits,
    input  logic [31:0]            stamp,
    input  logic                   value_error,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic [7:0]             wr_data,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr,
    input  logic [7:0]             rd_data,
    output logic                   beat_valid,
    input  logic                   beat_ready,
    output ctf_pkg::ctf_beat_t     beat
);

    localparam logic [AW-1:0] LAST_POS = AW'(NAME_BUFFER_SIZE - 2);

    ctf_pkg::ctf_state_t state_reg, state_next;

    logic [AW-1:0] wpos_reg, wpos_next;
    logic          full_reg, full_next;
    logic [AW-1:0] len_reg, len_next;
    logic          zero_reg, zero_next;
    logic [AW-1:0] len_emit_reg, len_emit_next;
    logic [AW-1:0] name_idx_reg, name_idx_next;
    logic [2:0]    byte_idx_reg, byte_idx_next;
    logic          err_reg, err_next;
    logic [63:0]   value_reg, value_next;
    logic [31:0]   stamp_reg, stamp_next;
    logic          in_fire;
    logic          is_cr;
    logic          fire;
    logic          name_done;

    assign in_ready  = (state_reg == ctf_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign is_cr     = (rx_byte == ctf_pkg::CARRIAGE_RETURN);
    assign fire      = beat_valid && beat_ready;
    assign name_done = (AW'(name_idx_reg + 1'b1) == len_emit_reg);

    // Name store write on any non-terminating byte while room is left.
    assign wr_en   = in_fire && !is_cr && !full_reg;
    assign wr_addr = wpos_reg;
    assign wr_data = rx_byte;
    assign rd_en   = (state_reg == ctf_pkg::ST_NAME_RD);
    assign rd_addr = name_idx_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctf_pkg::ST_IDLE:
            begin
                if (in_fire && is_cr)
                begin
                    state_next = ctf_pkg::ST_START;
                end
            end
            ctf_pkg::ST_START:
            begin
                if (fire)
                begin
                    state_next = ctf_pkg::ST_TYPE;
                end
            end
            ctf_pkg::ST_TYPE:
            begin
                if (fire)
                begin
                    if (err_reg)
                    begin
                        state_next = ctf_pkg::ST_IDLE;
                    end
                    else if (len_emit_reg == '0)
                    begin
                        state_next = ctf_pkg::ST_VTYPE;
                    end
                    else
                    begin
                        state_next = ctf_pkg::ST_NAME_RD;
                    end
                end
            end
            ctf_pkg::ST_NAME_RD:
            begin
                state_next = ctf_pkg::ST_NAME_OUT;
            end
            ctf_pkg::ST_NAME_OUT:
            begin
                if (fire)
                begin
                    state_next = name_done ? ctf_pkg::ST_VTYPE : ctf_pkg::ST_NAME_RD;
                end
            end
            ctf_pkg::ST_VTYPE:
            begin
                if (fire)
                begin
                    state_next = ctf_pkg::ST_VALUE;
                end
            end
            ctf_pkg::ST_VALUE:
            begin
                if (fire && byte_idx_reg == 3'd7)
                begin
                    state_next = ctf_pkg::ST_STAMP;
                end
            end
            ctf_pkg::ST_STAMP:
            begin
                if (fire && byte_idx_reg == 3'd3)
                begin
                    state_next = ctf_pkg::ST_END;
                end
            end
            ctf_pkg::ST_END:
            begin
                if (fire)
                begin
                    state_next = ctf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ctf_pkg::ST_IDLE;
            end
        endcase
    end

    // Beat toward the stuffer.
    always_comb
    begin
        beat_valid   = 1'b1;
        beat.data    = 8'h00;
        beat.content = 1'b1;
        beat.last    = 1'b0;
        case (state_reg)
            ctf_pkg::ST_START:
            begin
                beat.data    = ctf_pkg::BYTE_START;
                beat.content = 1'b0;
            end
            ctf_pkg::ST_TYPE:
            begin
                beat.data = ctf_pkg::TYPE_ANSWER;
                beat.last = err_reg;
            end
            ctf_pkg::ST_NAME_OUT:
            begin
                beat.data = rd_data;
            end
            ctf_pkg::ST_VTYPE:
            begin
                beat.data = ctf_pkg::VALUE_DOUBLE;
            end
            ctf_pkg::ST_VALUE:
            begin
                beat.data = value_reg[7:0];
            end
            ctf_pkg::ST_STAMP:
            begin
                beat.data = stamp_reg[7:0];
            end
            ctf_pkg::ST_END:
            begin
                beat.data    = ctf_pkg::BYTE_END;
                beat.content = 1'b0;
                beat.last    = 1'b1;
            end
            default:
            begin
                beat_valid = 1'b0;
            end
        endcase
    end

    // Store bookkeeping and telegram payload.
    always_comb
    begin
        wpos_next     = wpos_reg;
        full_next     = full_reg;
        len_next      = len_reg;
        zero_next     = zero_reg;
        len_emit_next = len_emit_reg;
        name_idx_next = name_idx_reg;
        byte_idx_next = byte_idx_reg;
        err_next      = err_reg;
        value_next    = value_reg;
        stamp_next    = stamp_reg;
        if (in_fire && is_cr)
        begin
            // Snapshot the name length and clear the store for the next command.
            len_emit_next = len_reg;
            name_idx_next = '0;
            err_next      = value_error;
            value_next    = value_bits;
            stamp_next    = stamp;
            wpos_next     = '0;
            full_next     = 1'b0;
            len_next      = '0;
            zero_next     = 1'b0;
        end
        else if (wr_en)
        begin
            if (!zero_reg)
            begin
                if (rx_byte == 8'h00)
                begin
                    zero_next = 1'b1;
                end
                else
                begin
                    len_next = len_reg + 1'b1;
                end
            end
            if (wpos_reg < LAST_POS)
            begin
                wpos_next = wpos_reg + 1'b1;
            end
            else
            begin
                full_next = 1'b1;
            end
        end
        if (fire)
        begin
            case (state_reg)
                ctf_pkg::ST_NAME_OUT:
                begin
                    name_idx_next = name_idx_reg + 1'b1;
                end
                ctf_pkg::ST_VTYPE:
                begin
                    byte_idx_next = '0;
                end
                ctf_pkg::ST_VALUE:
                begin
                    byte_idx_next = byte_idx_reg + 3'd1;
                    value_next    = value_reg >> 8;
                end
                ctf_pkg::ST_STAMP:
                begin
                    byte_idx_next = byte_idx_reg + 3'd1;
                    stamp_next    = stamp_reg >> 8;
                end
                default:
                begin
                    byte_idx_next = byte_idx_reg;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ctf_pkg::ST_IDLE;
            wpos_reg     <= '0;
            full_reg     <= 1'b0;
            len_reg      <= '0;
            zero_reg     <= 1'b0;
            len_emit_reg <= '0;
            name_idx_reg <= '0;
            byte_idx_reg <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wpos_reg     <= wpos_next;
            full_reg     <= full_next;
            len_reg      <= len_next;
            zero_reg     <= zero_next;
            len_emit_reg <= len_emit_next;
            name_idx_reg <= name_idx_next;
            byte_idx_reg <= byte_idx_next;
            err_reg      <= err_next;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        stamp_reg <= stamp_next;
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking testbench for command_telegram_framer.
// ============================================================================
// Command bytes are streamed into the framer with their answer value,
// timestamp and error flag. A scoreboard class keeps its own copy of the name
// store and builds the stuffed telegram expected for every carriage return.
// Each output beat is compared with the oldest expected byte. A short directed
// part covers the escape bytes, an empty name, a zero inside the name, a full
// store and a failed handler. It is followed by random command lines under
// several idle and stall patterns. One phase also holds the receiver off long
// enough for the framer to stall its input.
// ============================================================================
module tb_top;

    localparam int NAME_SIZE    = 16;
    localparam int STORE_SLOTS  = 16;
    localparam int ITEM_TARGET  = 500;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;

    // One command beat on the slave stream.
    typedef struct packed {
        logic [7:0]  rx;
        logic [63:0] value;
        logic [31:0] stamp;
        logic        err;
    } cmd_item_t;

    // One telegram beat on the master stream.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_beat_t;

    // Tracks the name store and holds the telegram bytes still to come.
    class telegram_predictor;
        logic [7:0] name_bytes [STORE_SLOTS];
        logic [3:0] wr_pos;
        bit         full;
        logic [4:0] name_len;
        bit         zero_hit;
        tx_beat_t   expected_beats [$];
        int         errors;

        function new();
            clear_name();
            errors = 0;
        endfunction

        function void clear_name();
            foreach (name_bytes[i]) name_bytes[i] = 8'h00;
            wr_pos   = '0;
            full     = 1'b0;
            name_len = '0;
            zero_hit = 1'b0;
        endfunction

        function void push_plain(logic [7:0] b);
            tx_beat_t beat;
            beat.data = b;
            beat.last = 1'b0;
            expected_beats.push_back(beat);
        endfunction

        // Content bytes that collide with a framing byte are escaped.
        function void push_content(logic [7:0] b);
            if (b == ctf_pkg::BYTE_START || b == ctf_pkg::BYTE_END ||
                b == ctf_pkg::BYTE_MARK)
            begin
                push_plain(ctf_pkg::BYTE_MARK);
                push_plain(b - 8'd1);
            end
            else
            begin
                push_plain(b);
            end
        endfunction

        // Called for every accepted command beat.
        function void note_command(cmd_item_t item);
            if (item.rx != ctf_pkg::CARRIAGE_RETURN)
            begin
                if (!full)
                begin
                    name_bytes[wr_pos] = item.rx;
                    if (!zero_hit)
                    begin
                        if (item.rx == 8'h00)
                            zero_hit = 1'b1;
                        else
                            name_len = name_len + 5'd1;
                    end
                    if (wr_pos < NAME_SIZE - 2)
                        wr_pos = wr_pos + 4'd1;
                    else
                        full = 1'b1;
                end
                return;
            end
            push_plain(ctf_pkg::BYTE_START);
            push_content(ctf_pkg::TYPE_ANSWER);
            if (!item.err)
            begin
                for (int i = 0; i < name_len && i < STORE_SLOTS; i++)
                    push_content(name_bytes[i]);
                push_content(ctf_pkg::VALUE_DOUBLE);
                for (int i = 0; i < 8; i++)
                    push_content(item.value[8*i +: 8]);
                for (int i = 0; i < 4; i++)
                    push_content(item.stamp[8*i +: 8]);
                push_plain(ctf_pkg::BYTE_END);
            end
            expected_beats[expected_beats.size() - 1].last = 1'b1;
            clear_name();
        endfunction

        // Called for every accepted telegram beat.
        function void check_beat(logic [7:0] data, logic last);
            tx_beat_t exp_beat;
            if (expected_beats.size() == 0)
            begin
                $error("tx_byte: unexpected beat, expected none, actual %h", data);
                errors++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            if (data !== exp_beat.data)
            begin
                $error("tx_byte mismatch: expected %h, actual %h", exp_beat.data, data);
                errors++;
            end
            if (last !== exp_beat.last)
            begin
                $error("last mismatch: expected %b, actual %b", exp_beat.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [ctf_pkg::IN_W-1:0] s_axis_tdata  = '0;
    logic [0:0]               s_axis_tuser  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [7:0]               m_axis_tdata;
    logic                     m_axis_tlast;

    telegram_predictor   predictor;
    int                  items_sent     = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_left      = 0;

    command_telegram_framer #(
        .NAME_BUFFER_SIZE(NAME_SIZE)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Random byte with a bias toward the bytes that need escaping and zero.
    function automatic logic [7:0] pick_content_byte();
        case ($urandom_range(7))
            0: return ctf_pkg::BYTE_START;
            1: return ctf_pkg::BYTE_END;
            2: return ctf_pkg::BYTE_MARK;
            3: return 8'h00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Drives one command beat and waits until the framer takes it.
    task automatic send_item(input cmd_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {item.stamp, item.value, item.rx};
        s_axis_tuser  <= item.err;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        predictor.note_command(item);
        items_sent++;
    endtask

    // Name byte; value, stamp and flag are random since the framer ignores them.
    task automatic send_byte(input logic [7:0] b);
        cmd_item_t item;
        item.rx    = b;
        item.value = {32'($urandom), 32'($urandom)};
        item.stamp = 32'($urandom);
        item.err   = 1'($urandom_range(1));
        send_item(item);
    endtask

    task automatic send_return(input logic [63:0] value, input logic [31:0] stamp,
                               input logic err);
        cmd_item_t item;
        item.rx    = ctf_pkg::CARRIAGE_RETURN;
        item.value = value;
        item.stamp = stamp;
        item.err   = err;
        send_item(item);
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            predictor.check_beat(m_axis_tdata, m_axis_tlast);
    end

    // Stimulus and end of run.
    initial
    begin
        logic [63:0] value;
        logic [31:0] stamp;
        logic [7:0]  b;
        int          name_count;
        int          phase;
        int          prev_phase;

        predictor = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty name with escape bytes and a carriage return code in the value.
        send_return(64'hCCBB_AA00_FFFF_0D02, 32'hAABB_CC0D, 1'b0);
        // Failed handler: start and type bytes only.
        send_return(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // Escaped name bytes, then a zero that cuts the name short.
        send_byte(ctf_pkg::BYTE_START);
        send_byte(ctf_pkg::BYTE_END);
        send_byte(ctf_pkg::BYTE_MARK);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h41);
        send_return(64'h0, 32'h0, 1'b0);
        // One byte more than the store holds; the last one is dropped.
        for (int i = 0; i < NAME_SIZE; i++)
            send_byte(8'h41 + 8'(i));
        send_return(64'h0123_4567_89AB_CDEF, 32'h89AB_CDEF, 1'b0);

        // Random command lines, phase chosen from the items sent so far.
        prev_phase = -1;
        while (items_sent < ITEM_TARGET)
        begin
            phase = (items_sent / PHASE_ITEMS) % 5;
            if (phase != prev_phase)
            begin
                case (phase)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                    3: begin send_idle_pct = 13; recv_stall_pct = 13; end
                    default:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                        hold_left      = HOLD_CYCLES;
                    end
                endcase
                prev_phase = phase;
            end
            if ($urandom_range(4) == 0)
                name_count = $urandom_range(NAME_SIZE - 1, NAME_SIZE + 4);
            else
                name_count = $urandom_range(NAME_SIZE - 2);
            for (int i = 0; i < name_count; i++)
            begin
                b = pick_content_byte();
                while (b == ctf_pkg::CARRIAGE_RETURN) b = pick_content_byte();
                send_byte(b);
            end
            for (int i = 0; i < 8; i++)
                value[8*i +: 8] = pick_content_byte();
            for (int i = 0; i < 4; i++)
                stamp[8*i +: 8] = pick_content_byte();
            send_return(value, stamp, ($urandom_range(7) == 0));
        end
        s_axis_tvalid <= 1'b0;

        // Drain the telegrams still in flight.
        recv_stall_pct = 0;
        while (predictor.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (predictor.errors == 0 && predictor.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
src/ctf_pkg.sv
src/ctf_name_ram.sv
src/ctf_stuff.sv
src/ctf_seq.sv
src/command_telegram_framer.sv
verif/tb_top.sv
